>>> rtl/msq_pkg.sv
// ----------------------------------------------------------------------------
// msq_pkg - shared types, constants and table functions of the scale quantiser
// Holds the built-in scale masks, the semitone ratio constants and the
// stage payload types that travel down the pipeline.
// ----------------------------------------------------------------------------
package msq_pkg;

  localparam int CAND_N = 128;  // candidate note slots, covers every note table
  localparam int IDX_W  = 7;
  localparam int VAL_W  = 20;
  localparam int BUILTIN_COUNT = 24;

  localparam logic [18:0] RATIO_MAX = 19'h7FFFF;
  localparam logic [19:0] FREQ_MAX  = 20'hFFFFF;

  // configuration register indexes
  localparam logic CFG_SCALE_SELECT = 1'b0;
  localparam logic CFG_ROOT_SHIFT   = 1'b1;

  // bit n set when scale note n is allowed
  localparam logic [11:0] BUILTIN_MASKS [BUILTIN_COUNT] = '{
    12'hFFF, 12'hAB5, 12'h5AD, 12'h9AD, 12'h295, 12'h4A9,
    12'hA95, 12'h529, 12'h555, 12'hB6D, 12'h891, 12'h491,
    12'h489, 12'h911, 12'h511, 12'h249, 12'h451, 12'h091,
    12'h089, 12'h111, 12'h049, 12'h081, 12'h041, 12'h101
  };

  // 2^(j/12) in Q1.24, rounded
  localparam logic [24:0] SEMI_Q24 [12] = '{
    25'd16777216, 25'd17774841, 25'd18831788, 25'd19951585,
    25'd21137968, 25'd22394897, 25'd23726566, 25'd25137421,
    25'd26632170, 25'd28215802, 25'd29893600, 25'd31671166
  };

  typedef struct packed {
    logic             action;
    logic [VAL_W-1:0] x;
    logic [11:0]      mask;
  } s1_t;

  typedef struct packed {
    logic              action;
    logic [VAL_W-1:0]  x;
    logic [CAND_N-1:0] below;
    logic [CAND_N-1:0] above;
  } s2_t;

  typedef struct packed {
    logic             action;
    logic [VAL_W-1:0] x;
    logic [IDX_W-1:0] lo_idx;
    logic             lo_ok;
    logic [IDX_W-1:0] hi_idx;
    logic             hi_ok;
  } s3_t;

  function automatic logic [11:0] builtin_mask(logic [6:0] sel);
    if (sel < 7'(BUILTIN_COUNT)) begin
      return BUILTIN_MASKS[sel[4:0]];
    end
    return 12'hFFF;
  endfunction

  // table frequency in Q16.4 Hz of note 12*oct + semi
  function automatic logic [19:0] note_freq(int oct, logic [3:0] semi);
    logic [63:0] v;
    v = 64'(880) * 64'(SEMI_Q24[semi]);
    v = v << oct;
    v = (v + (64'd1 << 23)) >> 24;
    return (v > 64'(FREQ_MAX)) ? FREQ_MAX : v[19:0];
  endfunction

  // 2^(oct + semi/12) in Q3.16, round half up, saturated
  function automatic logic [18:0] ratio_q16(int oct, logic [3:0] semi);
    int          s;
    logic [63:0] r;
    s = 8 - oct;
    if (s <= 0) begin
      return RATIO_MAX;
    end
    if (s > 62) begin
      return '0;
    end
    r = (64'(SEMI_Q24[semi]) + (64'd1 << (s - 1))) >> s;
    return (r > 64'(RATIO_MAX)) ? RATIO_MAX : r[18:0];
  endfunction

  // highest set bit, binary search in seven steps; msb of result is found
  function automatic logic [IDX_W:0] top_set(logic [CAND_N-1:0] v);
    logic [CAND_N-1:0] w;
    logic [IDX_W-1:0]  idx;
    w   = v;
    idx = '0;
    for (int b = IDX_W - 1; b >= 0; b--) begin
      if (|((w >> (1 << b)) & ((CAND_N'(1) << (1 << b)) - CAND_N'(1)))) begin
        idx[b] = 1'b1;
        w = w >> (1 << b);
      end
    end
    return {|v, idx};
  endfunction

  // lowest set bit, binary search in seven steps; msb of result is found
  function automatic logic [IDX_W:0] low_set(logic [CAND_N-1:0] v);
    logic [CAND_N-1:0] w;
    logic [IDX_W-1:0]  idx;
    w   = v;
    idx = '0;
    for (int b = IDX_W - 1; b >= 0; b--) begin
      if ((w & ((CAND_N'(1) << (1 << b)) - CAND_N'(1))) == '0) begin
        idx[b] = 1'b1;
        w = w >> (1 << b);
      end
    end
    return {|v, idx};
  endfunction

endpackage

>>> rtl/msq_cfg.sv
// ----------------------------------------------------------------------------
// msq_cfg - configuration registers and active scale mask
// Holds scale select and root shift, and forms the rotated 12-note mask.
// ----------------------------------------------------------------------------
module msq_cfg #(
  parameter int NUM_SCALES = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  output logic [11:0] mask
);
  import msq_pkg::*;

  logic [4:0]  scale_select;
  logic [3:0]  root_shift;
  logic [6:0]  sel_eff;
  logic [3:0]  shift_eff;
  logic [11:0] base;
  logic [23:0] twice;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_select <= '0;
      root_shift   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SCALE_SELECT: scale_select <= cfg_data;
        CFG_ROOT_SHIFT:   root_shift   <= cfg_data[3:0];
        default:          scale_select <= scale_select;
      endcase
    end
  end

  // clamp out-of-range selects to the last scale, shift modulo 12
  always_comb begin
    sel_eff   = (7'(scale_select) >= 7'(NUM_SCALES)) ? 7'(NUM_SCALES - 1)
                                                     : 7'(scale_select);
    shift_eff = (root_shift >= 4'd12) ? root_shift - 4'd12 : root_shift;
    base      = builtin_mask(sel_eff);
    twice     = {base, base} >> shift_eff;
    mask      = twice[11:0];
  end

endmodule

>>> rtl/msq_compare.sv
// ----------------------------------------------------------------------------
// msq_compare - candidate compare stage
// Compares the item against every note value and splits the allowed notes
// into those strictly below the item and those at or above it.
// ----------------------------------------------------------------------------
module msq_compare #(
  parameter int PITCH_SPAN = 48,
  parameter int FREQ_NOTES = 120
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  input  msq_pkg::s1_t   up_data,
  output logic           up_ready,
  output logic           dn_valid,
  output msq_pkg::s2_t   dn_data,
  input  logic           dn_ready
);
  import msq_pkg::*;

  logic [CAND_N-1:0] in_set;
  logic [CAND_N-1:0] cand_lt;

  for (genvar i = 0; i < CAND_N; i++) begin : g_cand
    localparam int          SEMI = i % 12;
    localparam int          OCT  = i / 12;
    localparam logic [19:0] FVAL = note_freq(OCT, 4'(SEMI));
    localparam logic [19:0] PVAL = 20'(i * 1024);
    localparam logic        P_OK = (i <= PITCH_SPAN);
    localparam logic        F_OK = (i < FREQ_NOTES);

    assign in_set[i]  = (up_data.action ? F_OK : P_OK) & up_data.mask[SEMI];
    assign cand_lt[i] = up_data.action ? (FVAL < up_data.x) : (PVAL < up_data.x);
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_data.action <= up_data.action;
      dn_data.x      <= up_data.x;
      dn_data.below  <= in_set & cand_lt;
      dn_data.above  <= in_set & ~cand_lt;
    end
  end

endmodule

>>> rtl/msq_search.sv
// ----------------------------------------------------------------------------
// msq_search - neighbour search stage
// Finds the nearest allowed note below the item and the nearest at or above.
// ----------------------------------------------------------------------------
module msq_search (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  input  msq_pkg::s2_t   up_data,
  output logic           up_ready,
  output logic           dn_valid,
  output msq_pkg::s3_t   dn_data,
  input  logic           dn_ready
);
  import msq_pkg::*;

  logic [IDX_W:0] lo;
  logic [IDX_W:0] hi;

  always_comb begin
    lo = top_set(up_data.below);
    hi = low_set(up_data.above);
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_data.action <= up_data.action;
      dn_data.x      <= up_data.x;
      dn_data.lo_ok  <= lo[IDX_W];
      dn_data.lo_idx <= lo[IDX_W-1:0];
      dn_data.hi_ok  <= hi[IDX_W];
      dn_data.hi_idx <= hi[IDX_W-1:0];
    end
  end

endmodule

>>> rtl/msq_select.sv
// ----------------------------------------------------------------------------
// msq_select - distance, choice and result stages
// Weighs the two neighbours, keeps the closer (lower on a tie), then looks
// up the ratio or frequency of the chosen note into the output register.
// ----------------------------------------------------------------------------
module msq_select #(
  parameter int PITCH_SPAN = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  input  msq_pkg::s3_t  up_data,
  output logic          up_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [6:0]    note_index,
  output logic [18:0]   pitch_ratio,
  output logic [19:0]   frequency_out
);
  import msq_pkg::*;

  logic [19:0]      freq_tab  [CAND_N];
  logic [18:0]      ratio_tab [CAND_N];
  logic [19:0]      lo_val;
  logic [19:0]      hi_val;
  logic [19:0]      d_lo;
  logic [19:0]      d_hi;
  logic [IDX_W-1:0] pick;
  logic             pick_valid;
  logic             pick_action;
  logic [IDX_W-1:0] pick_idx;
  logic             pick_ready;

  for (genvar i = 0; i < CAND_N; i++) begin : g_tab
    localparam int E   = i - PITCH_SPAN / 2;
    localparam int OCT = (E >= 0) ? E / 12 : -((11 - E) / 12);
    localparam int J   = E - 12 * OCT;

    assign freq_tab[i]  = note_freq(i / 12, 4'(i % 12));
    assign ratio_tab[i] = ratio_q16(OCT, 4'(J));
  end

  always_comb begin
    lo_val = up_data.action ? freq_tab[up_data.lo_idx] : 20'({up_data.lo_idx, 10'b0});
    hi_val = up_data.action ? freq_tab[up_data.hi_idx] : 20'({up_data.hi_idx, 10'b0});
    d_lo   = up_data.x - lo_val;
    d_hi   = hi_val - up_data.x;
    priority if (up_data.lo_ok && (!up_data.hi_ok || d_lo <= d_hi)) begin
      pick = up_data.lo_idx;
    end else if (up_data.hi_ok) begin
      pick = up_data.hi_idx;
    end else begin
      pick = '0;  // empty scale falls back to the lowest note
    end
  end

  assign pick_ready = !out_valid || out_ready;
  assign up_ready   = !pick_valid || pick_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pick_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (up_ready) begin
        pick_valid <= up_valid;
      end
      if (pick_ready) begin
        out_valid <= pick_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      pick_action <= up_data.action;
      pick_idx    <= pick;
    end
    if (pick_ready) begin
      note_index    <= pick_idx;
      pitch_ratio   <= pick_action ? '0 : ratio_tab[pick_idx];
      frequency_out <= pick_action ? freq_tab[pick_idx] : '0;
    end
  end

endmodule

>>> rtl/musical_scale_pitch_quantizer_core.sv
// ----------------------------------------------------------------------------
// musical_scale_pitch_quantizer_core - 12-tone scale quantiser, top level
// Snaps a semitone position or a frequency to the nearest note allowed by
// the selected, rotated scale mask and returns the note with its ratio or
// table frequency.
//
//   channel  handshake              beat contents
//   -------  ---------------------  --------------------------------------
//   in       in_valid / in_ready    action, pitch_position, frequency_in
//   out      out_valid / out_ready  note_index, pitch_ratio, frequency_out
//   cfg      cfg_valid / cfg_ready  cfg_index (0 scale, 1 root), cfg_data
//
// One beat per cycle sustained while out_ready stays high; each beat passes
// five registers: input register, compare, neighbour search, choice, result.
// Every stage register carries its own valid bit and advances when the stage
// after it is empty or moving, so a stall at out_ready backs up stage by
// stage without loss. Reset clears valid bits and the configuration; the
// scale masks are constants, so no clearing pass is needed. cfg_ready is
// always high.
// ----------------------------------------------------------------------------
module musical_scale_pitch_quantizer_core #(
  parameter int NUM_SCALES = 24,
  parameter int PITCH_SPAN = 48,
  parameter int FREQ_NOTES = 120
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [15:0] pitch_position,
  input  logic [19:0] frequency_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  note_index,
  output logic [18:0] pitch_ratio,
  output logic [19:0] frequency_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);
  import msq_pkg::*;

  // top of the pitch range in Q10.10
  localparam logic [19:0] PITCH_TOP = 20'(PITCH_SPAN * 1024);

  logic        [11:0] cfg_mask;
  logic        [19:0] pos_clamped;
  logic               s1_valid;
  s1_t                s1;
  logic               cmp_ready;
  logic               s2_valid;
  s2_t                s2;
  logic               srch_ready;
  logic               s3_valid;
  s3_t                s3;
  logic               sel_ready;

  assign cfg_ready = 1'b1;

  msq_cfg #(
    .NUM_SCALES (NUM_SCALES)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mask      (cfg_mask)
  );

  // saturate positions above the span
  assign pos_clamped = (20'(pitch_position) > PITCH_TOP) ? PITCH_TOP : 20'(pitch_position);

  // input register: accept whenever it is empty or moving on
  assign in_ready = !s1_valid || cmp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // capture the mask with the beat so it travels alongside it
  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1.action <= action;
      s1.x      <= action ? frequency_in : pos_clamped;
      s1.mask   <= cfg_mask;
    end
  end

  msq_compare #(
    .PITCH_SPAN (PITCH_SPAN),
    .FREQ_NOTES (FREQ_NOTES)
  ) u_compare (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s1_valid),
    .up_data  (s1),
    .up_ready (cmp_ready),
    .dn_valid (s2_valid),
    .dn_data  (s2),
    .dn_ready (srch_ready)
  );

  msq_search u_search (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s2_valid),
    .up_data  (s2),
    .up_ready (srch_ready),
    .dn_valid (s3_valid),
    .dn_data  (s3),
    .dn_ready (sel_ready)
  );

  msq_select #(
    .PITCH_SPAN (PITCH_SPAN)
  ) u_select (
    .clk           (clk),
    .rst           (rst),
    .up_valid      (s3_valid),
    .up_data       (s3),
    .up_ready      (sel_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .note_index    (note_index),
    .pitch_ratio   (pitch_ratio),
    .frequency_out (frequency_out)
  );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench of the 12-tone scale pitch quantiser
// Drives pitch and frequency beats through the quantiser under random gaps
// and back-pressure, predicts every result from an independent model of the
// scale masks, the root rotation and the nearest-note search, and compares
// each result beat field by field in arrival order. The scale and root
// registers are reprogrammed between phases, extremes and out-of-range
// values included.
// ----------------------------------------------------------------------------
module tb;

  localparam int SCALE_COUNT = 24;
  localparam int SPAN        = 48;
  localparam int NOTE_COUNT  = 120;
  localparam int PIPE_DEPTH  = 5;
  localparam int HALF_PERIOD = 6;

  localparam logic ACT_PITCH = 1'b0;
  localparam logic ACT_FREQ  = 1'b1;

  // bit n set when scale note n belongs to the scale
  localparam logic [11:0] SCALE_MASKS [SCALE_COUNT] = '{
    12'hFFF, 12'hAB5, 12'h5AD, 12'h9AD, 12'h295, 12'h4A9,
    12'hA95, 12'h529, 12'h555, 12'hB6D, 12'h891, 12'h491,
    12'h489, 12'h911, 12'h511, 12'h249, 12'h451, 12'h091,
    12'h089, 12'h111, 12'h049, 12'h081, 12'h041, 12'h101
  };

  // 2^(j/12) in Q1.24, rounded
  localparam longint unsigned SEMITONE_Q24 [12] = '{
    64'd16777216, 64'd17774841, 64'd18831788, 64'd19951585,
    64'd21137968, 64'd22394897, 64'd23726566, 64'd25137421,
    64'd26632170, 64'd28215802, 64'd29893600, 64'd31671166
  };

  typedef struct packed {
    logic [6:0]  note;
    logic [18:0] ratio;
    logic [19:0] hz;
  } note_result_t;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic        action         = ACT_PITCH;
  logic [15:0] pitch_position = '0;
  logic [19:0] frequency_in   = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [6:0]  note_index;
  logic [18:0] pitch_ratio;
  logic [19:0] frequency_out;
  logic        cfg_valid      = 1'b0;
  logic        cfg_ready;
  logic        cfg_index      = msq_pkg::CFG_SCALE_SELECT;
  logic [4:0]  cfg_data       = '0;

  // register shadow, updated on each accepted configuration beat
  logic [4:0]  cur_scale;
  logic [3:0]  cur_root;

  logic [19:0]  note_hz [NOTE_COUNT];
  note_result_t awaited_notes [$];
  int           errors    = 0;
  bit           stalls_on = 1'b1;
  int           rdy_hold  = 0;

  musical_scale_pitch_quantizer_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .pitch_position (pitch_position),
    .frequency_in   (frequency_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .note_index     (note_index),
    .pitch_ratio    (pitch_ratio),
    .frequency_out  (frequency_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Build the note frequency table in Q16.4 Hz: 55 Hz * 2^(i/12), saturated.
  initial begin
    longint unsigned v;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      v = (64'd880 * SEMITONE_Q24[i % 12]) << (i / 12);
      v = (v + (64'd1 << 23)) >> 24;
      note_hz[i] = (v > 64'hFFFFF) ? 20'hFFFFF : v[19:0];
    end
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    if (!stalls_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Nearest allowed note under the current scale and root. Ties keep the
  // lower note because only a strictly smaller distance replaces the best.
  function automatic note_result_t quantise_note(logic act, logic [15:0] pos,
                                                 logic [19:0] hz_in);
    note_result_t    res;
    logic [11:0]     pattern;
    logic [11:0]     allowed;
    int              sel;
    int              shift;
    int              best;
    bit              found;
    longint unsigned best_d;
    longint unsigned d;
    longint unsigned p;
    longint unsigned nk;
    int              e;
    int              oct;
    int              semi;
    int              s;
    longint unsigned r;
    sel     = (int'(cur_scale) >= SCALE_COUNT) ? SCALE_COUNT - 1 : int'(cur_scale);
    shift   = int'(cur_root) % 12;
    pattern = SCALE_MASKS[sel];
    for (int n = 0; n < 12; n++) begin
      allowed[n] = pattern[(n + shift) % 12];
    end
    best   = 0;
    found  = 1'b0;
    best_d = 0;
    res    = '0;
    if (act == ACT_PITCH) begin
      p = (pos > 16'(SPAN * 1024)) ? SPAN * 1024 : pos;
      for (int k = 0; k <= SPAN; k++) begin
        if (allowed[k % 12]) begin
          nk = k * 1024;
          d  = (p > nk) ? p - nk : nk - p;
          if (!found || d < best_d) begin
            best_d = d;
            best   = k;
            found  = 1'b1;
          end
        end
      end
      // ratio 2^((k - SPAN/2)/12) in Q3.16, round half up
      e    = best - SPAN / 2;
      oct  = (e >= 0) ? e / 12 : -((11 - e) / 12);
      semi = e - 12 * oct;
      s    = 8 - oct;
      if (s <= 0) begin
        r = 64'h7FFFF;
      end else begin
        r = (SEMITONE_Q24[semi] + (64'd1 << (s - 1))) >> s;
      end
      res.note  = 7'(best);
      res.ratio = (r > 64'h7FFFF) ? 19'h7FFFF : r[18:0];
    end else begin
      for (int k = 0; k < NOTE_COUNT; k++) begin
        if (allowed[k % 12]) begin
          d = (hz_in > note_hz[k]) ? hz_in - note_hz[k] : note_hz[k] - hz_in;
          if (!found || d < best_d) begin
            best_d = d;
            best   = k;
            found  = 1'b1;
          end
        end
      end
      res.note = 7'(best);
      res.hz   = note_hz[best];
    end
    return res;
  endfunction

  // Score every beat at the rising edge: check results against the oldest
  // expectation, then record what each accepted input beat should yield.
  always @(posedge clk) begin
    note_result_t want;
    if (rst) begin
      cur_scale <= '0;
      cur_root  <= '0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_notes.size() == 0) begin
          $error("result beat with nothing awaited: note_index %0d", note_index);
          errors++;
        end else begin
          want = awaited_notes.pop_front();
          if (note_index !== want.note) begin
            $error("note_index: expected %0d, got %0d", want.note, note_index);
            errors++;
          end
          if (pitch_ratio !== want.ratio) begin
            $error("pitch_ratio: expected %0d, got %0d", want.ratio, pitch_ratio);
            errors++;
          end
          if (frequency_out !== want.hz) begin
            $error("frequency_out: expected %0d, got %0d", want.hz, frequency_out);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_notes.insert(awaited_notes.size(),
                             quantise_note(action, pitch_position, frequency_in));
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == msq_pkg::CFG_SCALE_SELECT) begin
          cur_scale <= cfg_data;
        end else begin
          cur_root <= cfg_data[3:0];
        end
      end
    end
  end

  // Back-pressure on the result side: hold out_ready low for random stretches.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rdy_hold > 0) begin
      out_ready <= 1'b0;
      rdy_hold  <= rdy_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if (stalls_on && $urandom_range(0, 7) == 0) begin
        rdy_hold <= gap_len();
      end
    end
  end

  // Present one input beat after a random gap and hold it until accepted.
  // Valid stays high on return so a following beat can go back to back.
  task automatic send_note(logic act, logic [15:0] pos, logic [19:0] hz_in);
    int gap;
    gap = gap_len();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    action         <= act;
    pitch_position <= pos;
    frequency_in   <= hz_in;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(logic idx, logic [4:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop input valid, let every awaited result drain, then reprogram both
  // registers while the block is idle.
  task automatic set_scale(logic [4:0] scale_val, logic [4:0] root_val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_notes.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 3) @(posedge clk);
    write_reg(msq_pkg::CFG_SCALE_SELECT, scale_val);
    write_reg(msq_pkg::CFG_ROOT_SHIFT, root_val);
  endtask

  task automatic test_pitch_extremes();
    send_note(ACT_PITCH, 16'd0, 20'hFFFFF);
    send_note(ACT_PITCH, 16'd49152, 20'd0);       // top of the span
    send_note(ACT_PITCH, 16'hFFFF, 20'hFFFFF);     // saturates to the top
    send_note(ACT_PITCH, 16'd49153, 20'd0);
    send_note(ACT_PITCH, 16'd49151, 20'd0);
    send_note(ACT_PITCH, 16'd512, 20'd0);          // tie between notes 0 and 1
    send_note(ACT_PITCH, 16'd513, 20'd0);
    send_note(ACT_PITCH, 16'd24 * 16'd1024, 20'd0); // unity ratio
    send_note(ACT_PITCH, 16'h8000, 20'd0);
  endtask

  task automatic test_frequency_extremes();
    send_note(ACT_FREQ, 16'hFFFF, 20'd0);
    send_note(ACT_FREQ, 16'd0, 20'hFFFFF);           // beyond the top note
    send_note(ACT_FREQ, 16'd0, note_hz[0]);
    send_note(ACT_FREQ, 16'd0, note_hz[NOTE_COUNT - 1]);
    // exact and near midpoints, ties going to the lower note
    send_note(ACT_FREQ, 16'd0, 20'((note_hz[0] + note_hz[1]) >> 1));
    send_note(ACT_FREQ, 16'd0, 20'((note_hz[0] + note_hz[1] + 1) >> 1));
    send_note(ACT_FREQ, 16'd0, 20'((note_hz[60] + note_hz[61]) >> 1));
    send_note(ACT_FREQ, 16'd0, 20'((note_hz[60] + note_hz[61] + 1) >> 1));
  endtask

  task automatic test_register_extremes();
    // scale number past the table falls back to the last scale; root 15 wraps
    set_scale(5'd31, 5'd15);
    send_note(ACT_PITCH, 16'd1536, 20'd0);
    send_note(ACT_FREQ, 16'd0, note_hz[45]);
    set_scale(5'd23, 5'd11);
    send_note(ACT_PITCH, 16'd20000, 20'd0);
    send_note(ACT_FREQ, 16'd0, 20'd123456);
    // bit 4 of the root write is not part of the register
    set_scale(5'd1, 5'h13);
    send_note(ACT_PITCH, 16'd3000, 20'd0);
    send_note(ACT_FREQ, 16'd0, 20'd7000);
  endtask

  task automatic send_random_notes(int count);
    logic [15:0] pos;
    int          hz;
    int          i;
    int          spread;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 3))
        0, 1: pos = 16'($urandom_range(0, SPAN * 1024));
        2:    pos = 16'($urandom_range(0, SPAN) * 1024 + $urandom_range(0, 4) * 256
                        + $urandom_range(0, 2) - 1);
        default: pos = 16'($urandom_range(0, 16'hFFFF));
      endcase
      case ($urandom_range(0, 4))
        0: hz = $urandom_range(0, 20'hFFFFF);
        1: begin
          i      = $urandom_range(0, NOTE_COUNT - 1);
          spread = note_hz[i] >> 4;
          hz     = note_hz[i] - spread + $urandom_range(0, 2 * spread);
        end
        2: begin
          i  = $urandom_range(0, NOTE_COUNT - 6);
          hz = (note_hz[i] + note_hz[i + $urandom_range(1, 5)] + $urandom_range(0, 1)) >> 1;
        end
        3: hz = $urandom_range(0, 1500);
        default: hz = $urandom_range(850000, 20'hFFFFF);
      endcase
      send_note($urandom_range(0, 1) ? ACT_FREQ : ACT_PITCH, pos, 20'(hz));
    end
  endtask

  task automatic test_random_scales();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_scale(5'd0, 5'd0);
        1: set_scale(5'd23, 5'd11);
        2: set_scale(5'd31, 5'd15);
        default: set_scale(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
      endcase
      // run one phase flat out so back-to-back beats get through unbroken
      stalls_on = (ph != 3);
      send_random_notes(175);
      stalls_on = 1'b1;
    end
  endtask

  initial begin
    int guard;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_pitch_extremes();
    test_frequency_extremes();
    test_register_extremes();
    test_random_scales();

    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (awaited_notes.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (PIPE_DEPTH * 4) @(posedge clk);
    if (awaited_notes.size() != 0) begin
      $error("%0d expected results never arrived", awaited_notes.size());
      errors++;
    end

    if (errors == 0) begin
      $display("** musical_scale_pitch_quantizer_core: PASSED **");
    end else begin
      $display("** musical_scale_pitch_quantizer_core: FAILED **");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("** musical_scale_pitch_quantizer_core: FAILED **");
    $finish;
  end

endmodule
